[src/sha256_pkg.sv]
// Shared types, constants and helper functions of the SHA-256 message hasher.
package sha256_pkg;

  // One input transfer: a message byte and its framing flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_t;

  // One output transfer: a single digest word and its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } out_t;

  // Commands from the controller to the compression core.
  typedef struct packed {
    logic       start;
    logic       dig_rd;
    logic [2:0] dig_idx;
  } core_cmd_t;

  // Block memory read request from the compression core.
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
  } blk_rd_t;

  localparam logic [31:0] HashInit [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Places a byte big-endian into a word; the first byte starts a fresh word.
  function automatic logic [31:0] put_byte(input logic [31:0] acc, input logic [1:0] sel,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (sel)
      2'd0: r = {b, 24'd0};
      2'd1: r = {acc[31:24], b, 16'd0};
      2'd2: r = {acc[31:16], b, 8'd0};
      default: r = {acc[31:8], b};
    endcase
    return r;
  endfunction

endpackage

[src/sha256_message_hasher_top.sv]
// Top level of the SHA-256 message hasher: byte intake, block memory, padding and digest output.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i, in_stall_o | in_data_i: data_byte, byte_present, eom
//   out     | output    | out_valid_o, out_stall_i | out_data_o: digest_word, index, done
//
// The 64th byte of a block starts a compression: loading through 8 hash memory reads,
// 64 rounds at one per cycle, read-add-write back, and the done handoff.
// An end of message adds up to 16 block memory writes of padding, one or two compressions,
// and then eight digest transfers (memory read, then present).
// Reset clears the control state; hash words read as the initial values until first written.
// in_stall_o is high whenever a block, padding or digest sequence is under way.
module sha256_message_hasher_top import sha256_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_PAD  = 5'b00100,
    S_ORD  = 5'b01000,
    S_OUT  = 5'b10000
  } top_state_e;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_PAD  = 4'b0010,
    A_PAD2 = 4'b0100,
    A_OUT  = 4'b1000
  } after_e;

  top_state_e  state_q, state_d;
  after_e      after_q, after_d;
  logic [63:0] count_q, count_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  ptr_q, ptr_d;
  logic        first_q, first_d;
  logic        second_q, second_d;
  logic [2:0]  idx_q, idx_d;

  logic [31:0] bmem [16];
  logic [31:0] brd_q;
  logic        b_we;
  logic [3:0]  b_wa;
  logic [31:0] b_wd;

  core_cmd_t   cmd;
  blk_rd_t     blk_rd;
  logic        core_done;
  logic [31:0] core_word;

  logic        in_xfer;
  logic [31:0] acc_new, header, pad_word;
  logic        tail;

  sha256_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .blk_rd_data_i (brd_q),
    .blk_rd_o      (blk_rd),
    .done_o        (core_done),
    .hash_word_o   (core_word)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o.digest_word = core_word;
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.digest_done = (idx_q == 3'd7);

  assign acc_new = put_byte(acc_q, count_q[1:0], in_data_i.data_byte);
  assign header  = put_byte(acc_q, count_q[1:0], PadByte);
  // The block carries the bit length unless the pad byte landed past byte 55.
  assign tail    = second_q || (count_q[5:0] < LenStart);

  // Padding word for the current block memory position.
  always_comb begin
    if (first_q) begin
      pad_word = header;
    end else if (tail && ptr_q == 4'd14) begin
      pad_word = count_q[60:29];
    end else if (tail && ptr_q == 4'd15) begin
      pad_word = {count_q[28:0], 3'b000};
    end else begin
      pad_word = 32'd0;
    end
  end

  // Sequencer for intake, padding, compression and digest readout.
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    count_d = count_q;
    acc_d = acc_q;
    ptr_d = ptr_q;
    first_d = first_q;
    second_d = second_q;
    idx_d = idx_q;
    b_we = 1'b0;
    b_wa = ptr_q;
    b_wd = pad_word;
    cmd.start = 1'b0;
    cmd.dig_rd = 1'b0;
    cmd.dig_idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.byte_present) begin
            acc_d = acc_new;
            count_d = count_q + 64'd1;
            if (count_q[1:0] == 2'd3) begin
              b_we = 1'b1;
              b_wa = count_q[5:2];
              b_wd = acc_new;
            end
          end
          if (in_data_i.byte_present && count_q[5:0] == 6'h3f) begin
            cmd.start = 1'b1;
            state_d = S_CMP;
            after_d = in_data_i.end_of_message ? A_PAD : A_IDLE;
          end else if (in_data_i.end_of_message) begin
            state_d = S_PAD;
            ptr_d = count_d[5:2];
            first_d = 1'b1;
            second_d = 1'b0;
          end
        end
      end
      S_PAD: begin
        b_we = 1'b1;
        first_d = 1'b0;
        if (ptr_q == 4'd15) begin
          cmd.start = 1'b1;
          state_d = S_CMP;
          after_d = tail ? A_OUT : A_PAD2;
        end else begin
          ptr_d = ptr_q + 4'd1;
        end
      end
      S_CMP: begin
        if (core_done) begin
          case (after_q)
            A_PAD: begin
              state_d = S_PAD;
              ptr_d = count_q[5:2];
              first_d = 1'b1;
              second_d = 1'b0;
            end
            A_PAD2: begin
              state_d = S_PAD;
              ptr_d = 4'd0;
              first_d = 1'b0;
              second_d = 1'b1;
            end
            A_OUT: begin
              state_d = S_ORD;
              idx_d = 3'd0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ORD: begin
        cmd.dig_rd = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (idx_q == 3'd7) begin
            state_d = S_IDLE;
            count_d = 64'd0;
          end else begin
            idx_d = idx_q + 3'd1;
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= A_IDLE;
      count_q <= 64'd0;
      ptr_q <= 4'd0;
      first_q <= 1'b0;
      second_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      count_q <= count_d;
      ptr_q <= ptr_d;
      first_q <= first_d;
      second_q <= second_d;
      idx_q <= idx_d;
    end
  end

  // Word assembly register.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Block word memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    if (blk_rd.en) begin
      brd_q <= bmem[blk_rd.addr];
    end
  end

endmodule

[src/sha256_core.sv]
// Compression core: hash word memory, working variables, message schedule and rounds.
module sha256_core import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  core_cmd_t   cmd_i,
  input  logic [31:0] blk_rd_data_i,
  output blk_rd_t     blk_rd_o,
  output logic        done_o,
  output logic [31:0] hash_word_o
);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_LOAD  = 4'b0010,
    C_ROUND = 4'b0100,
    C_FOLD  = 4'b1000
  } core_state_e;

  core_state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [7:0]  hv_q;

  logic [31:0] hmem [8];
  logic [31:0] hrd_q;
  logic [2:0]  hrd_addr_q;
  logic        hrd_valid_q;
  logic [31:0] hash_rd;

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];

  logic        h_re, h_we;
  logic [2:0]  h_ra, h_wa;
  logic [31:0] h_wd;
  logic [6:0]  cnt_m1;
  logic [5:0]  rnd;
  logic [31:0] wt, t1, t2, ch, maj;

  // Entries never written since reset read as the initial hash values.
  assign hash_rd = hrd_valid_q ? hrd_q : HashInit[hrd_addr_q];
  assign hash_word_o = hash_rd;
  assign done_o = done_q;
  assign cnt_m1 = cnt_q - 7'd1;
  assign rnd = cnt_q[5:0];

  // Round function and message schedule.
  always_comb begin
    if (rnd < 6'd16) begin
      wt = blk_rd_data_i;
    end else begin
      wt = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
    end
    ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
    t1  = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[rnd] + wt;
    t2  = big_sigma0(v_q[0]) + maj;
  end

  // Memory port control and sequencing.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    h_re = 1'b0;
    h_ra = cnt_q[2:0];
    h_we = 1'b0;
    h_wa = cnt_m1[2:0];
    h_wd = hash_rd + v_q[0];
    blk_rd_o.en = 1'b0;
    blk_rd_o.addr = 4'd0;
    case (state_q)
      C_IDLE: begin
        if (cmd_i.dig_rd) begin
          // Digest readout also restores the initial value of the entry.
          h_re = 1'b1;
          h_ra = cmd_i.dig_idx;
          h_we = 1'b1;
          h_wa = cmd_i.dig_idx;
          h_wd = HashInit[cmd_i.dig_idx];
        end
        if (cmd_i.start) begin
          state_d = C_LOAD;
          cnt_d = 7'd0;
        end
      end
      C_LOAD: begin
        h_re = (cnt_q < 7'd8);
        if (cnt_q == 7'd8) begin
          blk_rd_o.en = 1'b1;
          state_d = C_ROUND;
          cnt_d = 7'd0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      C_ROUND: begin
        if (rnd < 6'd15) begin
          blk_rd_o.en = 1'b1;
          blk_rd_o.addr = rnd[3:0] + 4'd1;
        end
        if (rnd == 6'd63) begin
          state_d = C_FOLD;
          cnt_d = 7'd0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      C_FOLD: begin
        h_re = (cnt_q < 7'd8);
        h_we = (cnt_q != 7'd0);
        if (cnt_q == 7'd8) begin
          state_d = C_IDLE;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q <= 7'd0;
      done_q <= 1'b0;
      hv_q <= 8'd0;
      hrd_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
      if (h_we) begin
        hv_q[h_wa] <= 1'b1;
      end
      if (h_re) begin
        hrd_valid_q <= hv_q[h_ra];
      end
    end
  end

  // Hash word memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_wa] <= h_wd;
    end
    if (h_re) begin
      hrd_q <= hmem[h_ra];
      hrd_addr_q <= h_ra;
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_LOAD: begin
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_q[i] <= v_q[i+1];
          end
          v_q[7] <= hash_rd;
        end
      end
      C_ROUND: begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= wt;
      end
      C_FOLD: begin
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_q[i] <= v_q[i+1];
          end
          v_q[7] <= v_q[0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
